// ----- hdl/utf8d_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; imported by every module under hdl.
package utf8d_pkg;

  // One result word as it leaves the block
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        decode_error;
    logic        end_of_string;
  } utf8d_res_t;

  localparam logic [7:0]  LEAD2_MIN    = 8'hC2;
  localparam logic [7:0]  LEAD4_MAX    = 8'hF4;
  localparam logic [7:0]  CONT_MASK    = 8'hC0;
  localparam logic [7:0]  CONT_TAG     = 8'h80;
  localparam logic [7:0]  CONT_BITS    = 8'h3F;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [20:0] SURR_LO      = 21'h00D800;
  localparam logic [20:0] SURR_HI      = 21'h00DFFF;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [19:0] LO_TEN_MASK  = 20'h003FF;

  localparam utf8d_res_t RES_NONE = '{code_unit: 16'h0000, unit_valid: 1'b0,
                                      decode_error: 1'b0, end_of_string: 1'b0};

endpackage

// ----- hdl/utf8d_core.sv -----
// Per-byte UTF-8 decode step: sequence state registers and the logic that turns
// one byte into zero, one or two UTF-16 result words. Depends on utf8d_pkg.
module utf8d_core
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic [1:0] res_cnt,
  output utf8d_res_t res0,
  output utf8d_res_t res1
);

  logic [1:0]  pend_r, pend_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [20:0] part_r, part_nxt;
  logic        failed_r, failed_nxt;

  logic        accepted;
  logic        complete;
  logic        bad;
  logic [20:0] cp;
  logic [19:0] vofs;
  logic [20:0] vfull;

  always_comb begin
    pend_nxt   = pend_r;
    len_nxt    = len_r;
    part_nxt   = part_r;
    failed_nxt = failed_r;
    accepted   = 1'b0;
    res_cnt    = 2'd0;
    res0       = RES_NONE;
    res1       = RES_NONE;
    cp         = 21'd0;
    vfull      = 21'd0;
    vofs       = 20'd0;
    bad        = 1'b0;
    complete   = 1'b0;

    if (!failed_r) begin
      if (pend_r == 2'd0) begin
        if (data_byte[7] == 1'b0) begin
          part_nxt = {14'd0, data_byte[6:0]};
          len_nxt  = 3'd1;
          pend_nxt = 2'd0;
          accepted = 1'b1;
        end else if (data_byte >= LEAD2_MIN && data_byte <= 8'hDF) begin
          part_nxt = {16'd0, data_byte[4:0]};
          len_nxt  = 3'd2;
          pend_nxt = 2'd1;
          accepted = 1'b1;
        end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
          part_nxt = {17'd0, data_byte[3:0]};
          len_nxt  = 3'd3;
          pend_nxt = 2'd2;
          accepted = 1'b1;
        end else if (data_byte >= 8'hF0 && data_byte <= LEAD4_MAX) begin
          part_nxt = {18'd0, data_byte[2:0]};
          len_nxt  = 3'd4;
          pend_nxt = 2'd3;
          accepted = 1'b1;
        end else begin
          failed_nxt = 1'b1;
        end
      end else begin
        // a non-continuation byte fails the string, never restarts a sequence
        if ((data_byte & CONT_MASK) != CONT_TAG) begin
          failed_nxt = 1'b1;
        end else begin
          part_nxt = {part_r[14:0], data_byte[5:0] & CONT_BITS[5:0]};
          pend_nxt = pend_r - 2'd1;
          accepted = 1'b1;
        end
      end

      complete = accepted && (pend_nxt == 2'd0);
      if (complete) begin
        cp  = part_nxt;
        bad = (len_nxt == 3'd2 && cp < 21'h80) ||
              (len_nxt == 3'd3 && cp < 21'h800) ||
              (len_nxt == 3'd4 && cp < SUPP_BASE) ||
              (cp > CP_MAX) ||
              (cp >= SURR_LO && cp <= SURR_HI);
        vfull = cp - SUPP_BASE;
        vofs  = vfull[19:0];
        if (bad) begin
          failed_nxt = 1'b1;
        end else if (cp < SUPP_BASE) begin
          res0.code_unit  = cp[15:0];
          res0.unit_valid = 1'b1;
          res_cnt         = 2'd1;
        end else begin
          res0.code_unit  = HI_SURR_BASE | {6'd0, vofs[19:10]};
          res0.unit_valid = 1'b1;
          res1.code_unit  = LO_SURR_BASE | {6'd0, vofs[9:0] & LO_TEN_MASK[9:0]};
          res1.unit_valid = 1'b1;
          res_cnt         = 2'd2;
        end
        len_nxt  = 3'd0;
        part_nxt = 21'd0;
      end
    end

    if (last_byte) begin
      if (!failed_nxt && pend_nxt != 2'd0) begin
        failed_nxt = 1'b1;
      end
      // mark the final word of the string
      case (res_cnt)
        2'd2: begin
          res1.decode_error  = failed_nxt;
          res1.end_of_string = 1'b1;
        end
        2'd1: begin
          res0.decode_error  = failed_nxt;
          res0.end_of_string = 1'b1;
        end
        default: begin
          res0               = RES_NONE;
          res0.decode_error  = failed_nxt;
          res0.end_of_string = 1'b1;
          res_cnt            = 2'd1;
        end
      endcase
      pend_nxt   = 2'd0;
      len_nxt    = 3'd0;
      part_nxt   = 21'd0;
      failed_nxt = 1'b0;
    end

    if (!fire) begin
      res_cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 2'd0;
      len_r    <= 3'd0;
      part_r   <= 21'd0;
      failed_r <= 1'b0;
    end else if (fire) begin
      pend_r   <= pend_nxt;
      len_r    <= len_nxt;
      part_r   <= part_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ----- hdl/utf8d_outq.sv -----
// Four-word result queue: takes up to two words per cycle, hands out one unless out_stall holds it.
// Depends on utf8d_pkg for the result word type.
module utf8d_outq
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] wr_cnt,
  input  utf8d_res_t wr0,
  input  utf8d_res_t wr1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output utf8d_res_t head
);

  utf8d_res_t  mem_r [4];
  logic [1:0]  wptr_r, wptr_nxt;
  logic [1:0]  rptr_r, rptr_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r + wr_cnt;
    rptr_nxt = rptr_r + {1'b0, pop};
    cnt_nxt  = cnt_r + {1'b0, wr_cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem_r[wptr_r] <= wr0;
    end
    if (wr_cnt == 2'd2) begin
      mem_r[wptr_r + 2'd1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 2'd0;
      rptr_r <= 2'd0;
      cnt_r  <= 3'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/utf8_to_utf16_decoder.sv -----
// UTF-8 to UTF-16 decoder, top level: input byte register, decode step, result queue.
// An accepted byte waits in the input byte register; its words are registered in the queue.
// Throughput: one byte per cycle; no byte gives more than one word on average and the queue
// hands out one word per cycle, so the input stalls only while out_stall holds words back.
// Reset (rst_n, synchronous): decode state cleared, input stage and queue empty.
// Depends on utf8d_pkg, utf8d_core and utf8d_outq.
module utf8_to_utf16_decoder
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_unit_valid,
  output logic        out_decode_error,
  output logic        out_end_of_string
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       in_acc;
  logic       room;
  logic       adv;
  logic [1:0] res_cnt;
  utf8d_res_t res0, res1, head;

  assign in_stall = s1_valid_r && !room;
  assign in_acc   = in_valid && !in_stall;
  assign adv      = s1_valid_r && room;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  utf8d_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (adv),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  utf8d_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_cnt    (res_cnt),
    .wr0       (res0),
    .wr1       (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_code_unit     = head.code_unit;
  assign out_unit_valid    = head.unit_valid;
  assign out_decode_error  = head.decode_error;
  assign out_end_of_string = head.end_of_string;

  // a pair written in one cycle is always high surrogate then low surrogate
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt == 2'd2 |-> res0.code_unit[15:10] == 6'b110110 &&
                        res1.code_unit[15:10] == 6'b110111 &&
                        !res0.end_of_string)
    else $error("surrogate pair out of order");

  a_err_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decode_error |-> out_end_of_string)
    else $error("error flag on a word without end mark");

  a_unit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unit_valid && out_end_of_string |-> !out_decode_error)
    else $error("decoded unit flagged as failed string");

  a_empty_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_unit_valid |-> out_code_unit == 16'h0000 && out_end_of_string)
    else $error("word without unit carries data or lacks end mark");

endmodule
